/* rtl/fsb_pkg.sv */
package fsb_pkg;

    localparam int MAX_FRAME_SAMPLES = 1048576;
    localparam int SAMPLE_BITS       = 16;

    localparam int ADDR_W = $clog2(MAX_FRAME_SAMPLES);
    localparam int LEN_W  = $clog2(MAX_FRAME_SAMPLES + 1);

    localparam int SAMPLE_W    = 16;
    localparam int INDEX_W     = 10;
    localparam int DIFF_W      = 36;
    localparam int FPB_W       = 10;
    localparam int SPF_W       = 21;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 1;

    localparam int NUM_STORES = 3;
    localparam int STORE_W    = 2;

    localparam int RESULT_DEPTH = 3;
    localparam int RES_PTR_W    = $clog2(RESULT_DEPTH);
    localparam int RES_CNT_W    = $clog2(RESULT_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_PER_BLOCK  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_FRAME = 1'b1;

    localparam logic [FPB_W-1:0] FPB_RESET = 10'd10;
    localparam logic [SPF_W-1:0] SPF_RESET = 21'd1048576;

    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

    typedef logic [STORE_W-1:0] t_store_id;

    localparam t_store_id STORE_0 = 2'd0;
    localparam t_store_id STORE_1 = 2'd1;
    localparam t_store_id STORE_2 = 2'd2;

    typedef logic [NUM_STORES-1:0][SAMPLE_BITS-1:0] t_rd_data;

    typedef struct packed {
        logic                   valid;
        logic [ADDR_W-1:0]      pos;
        logic                   eof;
        logic [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic                   we;
        t_store_id              store;
        logic [ADDR_W-1:0]      addr;
        logic [SAMPLE_BITS-1:0] data;
    } t_wr;

    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic [DIFF_W-1:0]  chosen_difference;
        logic               is_initial;
    } t_result;

endpackage

/* rtl/fsb_in_if.sv */
interface fsb_in_if;
    logic                          valid;
    logic                          ready;
    logic [fsb_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/fsb_out_if.sv */
interface fsb_out_if;
    logic                         valid;
    logic                         ready;
    logic [fsb_pkg::INDEX_W-1:0]  chosen_index;
    logic [fsb_pkg::DIFF_W-1:0]   chosen_difference;
    logic                         is_initial;

    modport source (output valid, output chosen_index, output chosen_difference,
                    output is_initial, input ready);
    modport sink   (input valid, input chosen_index, input chosen_difference,
                    input is_initial, output ready);
endinterface

/* rtl/fsb_ram.sv */
module fsb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fsb_result_fifo.sv */
module fsb_result_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  fsb_pkg::t_result                i_push_data,
    output logic [fsb_pkg::RES_CNT_W-1:0]   o_count,
    fsb_out_if.source                       o_out
);

    fsb_pkg::t_result                     r_mem [fsb_pkg::RESULT_DEPTH];
    logic [fsb_pkg::RES_PTR_W-1:0]        r_head, n_head;
    logic [fsb_pkg::RES_PTR_W-1:0]        r_tail, n_tail;
    logic [fsb_pkg::RES_CNT_W-1:0]        r_count, n_count;
    logic                                 pop;

    localparam logic [fsb_pkg::RES_PTR_W-1:0] LAST_PTR =
        fsb_pkg::RES_PTR_W'(fsb_pkg::RESULT_DEPTH - 1);

    assign pop = o_out.valid && o_out.ready;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (pop) begin
            n_head = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
        end
        if (i_push) begin
            n_tail = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_data;
        end
    end

    assign o_count                 = r_count;
    assign o_out.valid             = (r_count != '0);
    assign o_out.chosen_index      = r_mem[r_head].chosen_index;
    assign o_out.chosen_difference = r_mem[r_head].chosen_difference;
    assign o_out.is_initial        = r_mem[r_head].is_initial;

endmodule

/* rtl/fsb_score.sv */
module fsb_score (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fsb_pkg::t_item                 i_item,
    input  fsb_pkg::t_rd_data              i_rd_data,
    input  logic [fsb_pkg::FPB_W-1:0]      i_frames_per_block,
    output fsb_pkg::t_wr                   o_wr,
    output logic                           o_push,
    output fsb_pkg::t_result               o_result
);

    fsb_pkg::t_store_id                  r_role_ref, n_role_ref;
    fsb_pkg::t_store_id                  r_role_best, n_role_best;
    fsb_pkg::t_store_id                  r_role_in, n_role_in;
    logic                                r_have_ref, n_have_ref;
    logic [fsb_pkg::INDEX_W-1:0]         r_frame_in_block, n_frame_in_block;
    logic [fsb_pkg::DIFF_W-1:0]          r_running, n_running;
    logic [fsb_pkg::DIFF_W-1:0]          r_best_diff, n_best_diff;
    logic [fsb_pkg::INDEX_W-1:0]         r_best_pos, n_best_pos;

    logic [fsb_pkg::SAMPLE_BITS-1:0]     ref_sample;
    logic [fsb_pkg::SAMPLE_BITS-1:0]     abs_diff;
    logic [fsb_pkg::DIFF_W:0]            sum_wide;
    logic [fsb_pkg::DIFF_W-1:0]          sum;
    logic [fsb_pkg::INDEX_W-1:0]         frame_next;
    fsb_pkg::t_store_id                  role_best_mid;

    // reference sample and its distance to the incoming one
    always_comb begin
        ref_sample = i_rd_data[r_role_ref];
        if (i_item.sample > ref_sample) begin
            abs_diff = i_item.sample - ref_sample;
        end else begin
            abs_diff = ref_sample - i_item.sample;
        end
        sum_wide = {1'b0, r_running} + (fsb_pkg::DIFF_W + 1)'(abs_diff);
        sum      = sum_wide[fsb_pkg::DIFF_W] ? fsb_pkg::DIFF_MAX
                                             : sum_wide[fsb_pkg::DIFF_W-1:0];
    end

    // store write: first frame fills reference, later frames fill incoming
    always_comb begin
        o_wr.we    = i_item.valid;
        o_wr.store = r_have_ref ? r_role_in : r_role_ref;
        o_wr.addr  = i_item.pos;
        o_wr.data  = i_item.sample;
    end

    always_comb begin
        n_role_ref       = r_role_ref;
        n_role_best      = r_role_best;
        n_role_in        = r_role_in;
        n_have_ref       = r_have_ref;
        n_frame_in_block = r_frame_in_block;
        n_running        = r_running;
        n_best_diff      = r_best_diff;
        n_best_pos       = r_best_pos;
        o_push           = 1'b0;
        o_result         = '0;
        frame_next       = r_frame_in_block + 1'b1;
        role_best_mid    = r_role_best;

        if (i_item.valid) begin
            if (r_have_ref) begin
                n_running = sum;
            end
            if (i_item.eof) begin
                n_running = '0;
                if (!r_have_ref) begin
                    n_have_ref          = 1'b1;
                    o_push              = 1'b1;
                    o_result.is_initial = 1'b1;
                end else begin
                    if (r_frame_in_block == '0 || sum < r_best_diff) begin
                        n_best_diff   = sum;
                        n_best_pos    = r_frame_in_block;
                        role_best_mid = r_role_in;
                        n_role_in     = r_role_best;
                    end
                    n_role_best = role_best_mid;
                    if (frame_next < i_frames_per_block) begin
                        n_frame_in_block = frame_next;
                    end else begin
                        o_push                     = 1'b1;
                        o_result.chosen_index      = n_best_pos;
                        o_result.chosen_difference = n_best_diff;
                        o_result.is_initial        = 1'b0;
                        // winner becomes the new reference
                        n_role_ref       = role_best_mid;
                        n_role_best      = r_role_ref;
                        n_frame_in_block = '0;
                        n_best_diff      = fsb_pkg::DIFF_MAX;
                        n_best_pos       = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role_ref       <= fsb_pkg::STORE_0;
            r_role_best      <= fsb_pkg::STORE_1;
            r_role_in        <= fsb_pkg::STORE_2;
            r_have_ref       <= 1'b0;
            r_frame_in_block <= '0;
            r_running        <= '0;
            r_best_diff      <= fsb_pkg::DIFF_MAX;
            r_best_pos       <= '0;
        end else begin
            r_role_ref       <= n_role_ref;
            r_role_best      <= n_role_best;
            r_role_in        <= n_role_in;
            r_have_ref       <= n_have_ref;
            r_frame_in_block <= n_frame_in_block;
            r_running        <= n_running;
            r_best_diff      <= n_best_diff;
            r_best_pos       <= n_best_pos;
        end
    end

endmodule

/* rtl/best_frame_selector_sad.sv */
// Best-frame selector. Takes one sample word per clock with no bubbles while
// the result queue has room; the first frame after reset is stored as the
// reference and reported with is_initial set, and each following group of
// frames_per_block frames reports the frame with the smallest sum of absolute
// differences to the reference (earliest on a tie), which then becomes the new
// reference. A result word is queued when the last sample of its frame is
// scored. Each sample reads all three frame stores at its position in the
// accept cycle and is scored and written back next cycle, with the write
// of the previous sample forwarded when both hit the same entry; ready drops
// only when the three-deep result queue backs up. The frame stores are not
// cleared after reset, so the block accepts samples from the first cycle.
module best_frame_selector_sad (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    fsb_in_if.sink                              i_in,
    fsb_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [fsb_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [fsb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [fsb_pkg::FPB_W-1:0]        r_frames_per_block;
    logic [fsb_pkg::SPF_W-1:0]        r_samples_per_frame;
    logic [fsb_pkg::ADDR_W-1:0]       r_pos, n_pos;
    fsb_pkg::t_item                   r_item;
    logic [fsb_pkg::NUM_STORES-1:0]   r_fwd;
    logic [fsb_pkg::SAMPLE_BITS-1:0]  r_fwd_data;

    logic [fsb_pkg::LEN_W-1:0]        frame_len;
    logic [fsb_pkg::FPB_W-1:0]        fpb_eff;
    logic                             eof;
    logic                             accept;
    logic [fsb_pkg::RES_CNT_W-1:0]    res_count;
    fsb_pkg::t_rd_data                ram_rdata;
    fsb_pkg::t_rd_data                rd_data;
    fsb_pkg::t_wr                     wr;
    logic                             push;
    fsb_pkg::t_result                 result;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_per_block  <= fsb_pkg::FPB_RESET;
            r_samples_per_frame <= fsb_pkg::SPF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fsb_pkg::REG_FRAMES_PER_BLOCK: begin
                    r_frames_per_block <= i_cfg_data[fsb_pkg::FPB_W-1:0];
                end
                fsb_pkg::REG_SAMPLES_PER_FRAME: begin
                    r_samples_per_frame <= i_cfg_data[fsb_pkg::SPF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_samples_per_frame == '0) begin
            frame_len = fsb_pkg::LEN_W'(1);
        end else if (32'(r_samples_per_frame) > 32'(fsb_pkg::MAX_FRAME_SAMPLES)) begin
            frame_len = fsb_pkg::LEN_W'(fsb_pkg::MAX_FRAME_SAMPLES);
        end else begin
            frame_len = fsb_pkg::LEN_W'(r_samples_per_frame);
        end
        fpb_eff = (r_frames_per_block == '0) ? fsb_pkg::FPB_W'(1) : r_frames_per_block;
    end

    // accept stage: sample position and store reads
    assign i_in.ready = ({1'b0, res_count} + (fsb_pkg::RES_CNT_W + 1)'(r_item.valid))
                        < (fsb_pkg::RES_CNT_W + 1)'(fsb_pkg::RESULT_DEPTH);
    assign accept     = i_in.valid && i_in.ready;
    assign eof        = (fsb_pkg::LEN_W'(r_pos) + fsb_pkg::LEN_W'(1)) >= frame_len;

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = eof ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item.valid <= accept;
        end
        if (accept) begin
            r_item.pos    <= r_pos;
            r_item.eof    <= eof;
            r_item.sample <= i_in.sample[fsb_pkg::SAMPLE_BITS-1:0];
            r_fwd_data    <= wr.data;
            for (int k = 0; k < fsb_pkg::NUM_STORES; k++) begin
                r_fwd[k] <= wr.we && (wr.store == fsb_pkg::t_store_id'(k))
                            && (wr.addr == r_pos);
            end
        end
    end

    for (genvar k = 0; k < fsb_pkg::NUM_STORES; k++) begin : g_store
        fsb_ram #(
            .DEPTH (fsb_pkg::MAX_FRAME_SAMPLES),
            .WIDTH (fsb_pkg::SAMPLE_BITS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr.we && (wr.store == fsb_pkg::t_store_id'(k))),
            .i_waddr (wr.addr),
            .i_wdata (wr.data),
            .i_re    (accept),
            .i_raddr (r_pos),
            .o_rdata (ram_rdata[k])
        );

        // same-entry write in the read cycle
        assign rd_data[k] = r_fwd[k] ? r_fwd_data : ram_rdata[k];
    end

    fsb_score u_score (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item             (r_item),
        .i_rd_data          (rd_data),
        .i_frames_per_block (fpb_eff),
        .o_wr               (wr),
        .o_push             (push),
        .o_result           (result)
    );

    fsb_result_fifo u_result_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (result),
        .o_count     (res_count),
        .o_out       (o_out)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import fsb_pkg::*;

    localparam int STORE_CAP     = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 120;
    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 1250;

    typedef enum int {FILL_RANDOM, FILL_NEAR_REF, FILL_LOW, FILL_RAILS} t_fill;

    class best_frame_tracker;
        bit [SAMPLE_BITS-1:0] frame_mem [NUM_STORES][STORE_CAP];
        int unsigned          mem_fill [NUM_STORES];
        bit [FPB_W-1:0]       frames_per_block;
        bit [SPF_W-1:0]       samples_per_frame;
        t_store_id            ref_id, best_id, in_id;
        int unsigned          position;
        bit [INDEX_W-1:0]     frame_idx;
        bit [DIFF_W-1:0]      run_sad, best_sad;
        bit [INDEX_W-1:0]     best_idx;
        bit                   have_ref;
        t_result              expected_choices [$];
        int                   errors;
        int                   choices_made;

        function new();
            frames_per_block  = FPB_RESET;
            samples_per_frame = SPF_RESET;
            ref_id   = STORE_0;
            best_id  = STORE_1;
            in_id    = STORE_2;
            best_sad = DIFF_MAX;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FRAMES_PER_BLOCK) frames_per_block = data[FPB_W-1:0];
            else if (idx == REG_SAMPLES_PER_FRAME) samples_per_frame = data[SPF_W-1:0];
        endfunction

        function int unsigned frame_length();
            int unsigned n;
            n = samples_per_frame;
            if (n == 0) n = 1;
            if (n > MAX_FRAME_SAMPLES) n = MAX_FRAME_SAMPLES;
            return n;
        endfunction

        // longest frame that never reads a reference entry left unwritten
        function int unsigned longest_safe_frame();
            int unsigned lim;
            lim = mem_fill[ref_id];
            if (frame_idx != 0 && mem_fill[best_id] < lim) lim = mem_fill[best_id];
            return lim;
        endfunction

        function bit [SAMPLE_BITS-1:0] reference_here();
            if (position < STORE_CAP) return frame_mem[ref_id][position];
            return '0;
        endfunction

        function void store_sample(t_store_id id, int unsigned pos, bit [SAMPLE_BITS-1:0] s);
            if (pos < STORE_CAP) begin
                frame_mem[id][pos] = s;
                if (pos == mem_fill[id]) mem_fill[id] = pos + 1;
            end
        endfunction

        function void post_choice(bit [INDEX_W-1:0] idx, bit [DIFF_W-1:0] sad, bit first_flag);
            t_result e;
            e.chosen_index      = idx;
            e.chosen_difference = sad;
            e.is_initial        = first_flag;
            expected_choices.push_back(e);
            choices_made++;
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] word);
            int unsigned          len, pos;
            bit [SAMPLE_BITS-1:0] s, r, d;
            bit [DIFF_W:0]        acc;
            bit [INDEX_W-1:0]     blk;
            t_store_id            tmp;
            len = frame_length();
            pos = position;
            if (pos >= MAX_FRAME_SAMPLES) pos = MAX_FRAME_SAMPLES - 1;
            s = word[SAMPLE_BITS-1:0];
            if (!have_ref) begin
                store_sample(ref_id, pos, s);
            end else begin
                r = (pos < STORE_CAP) ? frame_mem[ref_id][pos] : '0;
                d = (s > r) ? s - r : r - s;
                store_sample(in_id, pos, s);
                acc = run_sad + d;
                run_sad = (acc > DIFF_MAX) ? DIFF_MAX : acc[DIFF_W-1:0];
            end
            if (pos + 1 < len) begin
                position = pos + 1;
                return;
            end
            position = 0;
            if (!have_ref) begin
                have_ref = 1'b1;
                run_sad  = '0;
                post_choice('0, '0, 1'b1);
                return;
            end
            // first frame of a block always wins, later ones only when strictly better
            if (frame_idx == 0 || run_sad < best_sad) begin
                best_sad = run_sad;
                best_idx = frame_idx;
                tmp      = best_id;
                best_id  = in_id;
                in_id    = tmp;
            end
            run_sad = '0;
            blk = frames_per_block;
            if (blk == 0) blk = 1;
            frame_idx = frame_idx + 1'b1;
            if (frame_idx < blk) return;
            post_choice(best_idx, best_sad, 1'b0);
            tmp       = ref_id;
            ref_id    = best_id;
            best_id   = tmp;
            frame_idx = '0;
            best_sad  = DIFF_MAX;
            best_idx  = '0;
        endfunction

        function void check_choice(logic [INDEX_W-1:0] idx, logic [DIFF_W-1:0] sad,
                                   logic first_flag);
            t_result e;
            if (expected_choices.size() == 0) begin
                $error({"unexpected result word: chosen_index=%0d ",
                        "chosen_difference=%0d is_initial=%0b"},
                       idx, sad, first_flag);
                errors++;
                return;
            end
            e = expected_choices.pop_front();
            if (idx !== e.chosen_index) begin
                $error("chosen_index: expected %0d, got %0d", e.chosen_index, idx);
                errors++;
            end
            if (sad !== e.chosen_difference) begin
                $error("chosen_difference: expected %0d, got %0d", e.chosen_difference, sad);
                errors++;
            end
            if (first_flag !== e.is_initial) begin
                $error("is_initial: expected %0b, got %0b", e.is_initial, first_flag);
                errors++;
            end
        endfunction

        function void report_leftovers();
            if (expected_choices.size() != 0) begin
                $error("%0d expected result words never arrived", expected_choices.size());
                errors += expected_choices.size();
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    bit                     long_hold_req;
    int unsigned            samples_sent;

    fsb_in_if  in_if ();
    fsb_out_if out_if ();

    best_frame_tracker tracker = new();

    best_frame_selector_sad DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [SAMPLE_W-1:0] next_sample(t_fill fill);
        logic [SAMPLE_W-1:0] r;
        r = tracker.reference_here();
        case (fill)
            FILL_NEAR_REF: begin
                if ($urandom_range(0, 1) != 0) return r;
                return r ^ SAMPLE_W'($urandom_range(1, 3));
            end
            FILL_LOW: return SAMPLE_W'($urandom_range(0, 3));
            FILL_RAILS: begin
                if ($urandom_range(0, 1) != 0) return {SAMPLE_W{1'b1}};
                return {SAMPLE_W{1'b0}};
            end
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] word);
        in_if.valid  <= 1'b1;
        in_if.sample <= word;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        tracker.take_sample(word);
        samples_sent++;
    endtask

    task automatic send_stream(input int unsigned count, input t_fill fill);
        int unsigned burst, gap;
        burst = $urandom_range(1, 24);
        for (int unsigned k = 0; k < count; k++) begin
            send_sample(next_sample(fill));
            if (burst > 1) begin
                burst--;
            end else begin
                burst = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0 && k + 1 < count) begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        in_if.valid <= 1'b0;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        tracker.set_register(idx, data);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_for_choices();
        while (tracker.expected_choices.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [SAMPLE_W-1:0] pattern_words [8];
        int unsigned         phase, lim, spf, fpb, count;
        t_fill               fill;
        in_if.valid   = 1'b0;
        in_if.sample  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        i_rst_n       = 1'b0;
        long_hold_req = 1'b0;
        samples_sent  = 0;
        pattern_words = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                          16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reference frame built across length changes
        write_register(REG_SAMPLES_PER_FRAME, SPF_RESET);
        write_register(REG_FRAMES_PER_BLOCK, '0);
        foreach (pattern_words[k]) send_sample(pattern_words[k]);
        in_if.valid <= 1'b0;
        wait_for_choices();
        write_register(REG_SAMPLES_PER_FRAME, {CFG_DATA_W{1'b1}});
        repeat (16) send_sample(next_sample(FILL_RANDOM));
        in_if.valid <= 1'b0;
        wait_for_choices();
        // length dropped below the position reached
        write_register(REG_SAMPLES_PER_FRAME, '0);
        send_sample(16'h8001);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        in_if.valid <= 1'b0;

        phase = 0;
        samples_sent = 0;
        while (samples_sent < RANDOM_ITEMS) begin
            wait_for_choices();
            lim   = tracker.longest_safe_frame();
            fill  = t_fill'($urandom_range(0, 3));
            count = $urandom_range(8, 60);
            case (phase)
                0: begin
                    fpb = 1;
                    spf = lim;
                end
                2: begin
                    fpb = 1;
                    spf = 1;
                    count = 60;
                    long_hold_req = 1'b1;
                end
                4: begin
                    fpb = 1023;
                    spf = 1;
                    count = 1030;
                    fill = FILL_LOW;
                end
                6: begin
                    fpb = 1000;
                    spf = lim;
                end
                default: begin
                    fpb = $urandom_range(0, 6);
                    case ($urandom_range(0, 4))
                        0:       spf = $urandom_range(0, 1);
                        1, 2:    spf = $urandom_range(1, (lim < 6) ? lim : 6);
                        3:       spf = $urandom_range(1, lim);
                        default: spf = lim;
                    endcase
                end
            endcase
            write_register(REG_FRAMES_PER_BLOCK, CFG_DATA_W'(fpb));
            write_register(REG_SAMPLES_PER_FRAME, CFG_DATA_W'(spf));
            send_stream(count, fill);
            phase++;
        end
        wait_for_choices();
        tracker.report_leftovers();
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : result_sink
        int unsigned cyc;
        out_if.ready = 1'b0;
        cyc = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                tracker.check_choice(out_if.chosen_index, out_if.chosen_difference,
                                     out_if.is_initial);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                case ((cyc / 200) % 4)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= ($urandom_range(0, 1) != 0);
                    2:       out_if.ready <= (cyc % 4 == 0);
                    default: out_if.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/fsb_pkg.sv
rtl/fsb_in_if.sv
rtl/fsb_out_if.sv
rtl/fsb_ram.sv
rtl/fsb_result_fifo.sv
rtl/fsb_score.sv
rtl/best_frame_selector_sad.sv
dv/tb_top.sv
